// File: hdl/drtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_pkg
// Shared types and constants of the descriptor ratio-test matcher.
// ----------------------------------------------------------------------------
package drtm_pkg;

    // Function codes carried with every input transaction
    localparam logic [1:0] FUNC_REF = 2'd0;
    localparam logic [1:0] FUNC_QRY = 2'd1;
    localparam logic [1:0] FUNC_CLR = 2'd2;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam int          INPUT_LANES = 8;
    localparam int          ELEM_W      = 8;
    localparam int          RATIO_W     = 17;
    localparam int          QIDX_W      = 16;
    localparam int          MIDX_W      = 10;
    localparam int          ODIST_W     = 23;
    localparam int          FRAC_W      = 16;
    localparam logic [16:0] RATIO_RESET = 17'd41943;
    localparam logic [22:0] DIST_SAT    = 23'h7FFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_CHUNK,
        ST_SCAN,
        ST_DRAIN,
        ST_RATIO,
        ST_RESULT
    } t_state;

    // Tag that travels with a chunk read through the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_dist_tag;

endpackage

// File: hdl/drtm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_in_if
// Input channel: one descriptor chunk or a command per transaction.
// ----------------------------------------------------------------------------
interface drtm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] elem_0;
    logic [7:0] elem_1;
    logic [7:0] elem_2;
    logic [7:0] elem_3;
    logic [7:0] elem_4;
    logic [7:0] elem_5;
    logic [7:0] elem_6;
    logic [7:0] elem_7;
    logic       last_chunk;

    modport source (
        output valid, func, elem_0, elem_1, elem_2, elem_3,
               elem_4, elem_5, elem_6, elem_7, last_chunk,
        input  ready
    );
    modport sink (
        input  valid, func, elem_0, elem_1, elem_2, elem_3,
               elem_4, elem_5, elem_6, elem_7, last_chunk,
        output ready
    );
endinterface

// File: hdl/drtm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_out_if
// Output channel: one match result per completed query descriptor.
// ----------------------------------------------------------------------------
interface drtm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] query_index;
    logic [9:0]  match_index;
    logic        matched;
    logic [22:0] best_distance_sq;

    modport source (
        output valid, query_index, match_index, matched, best_distance_sq,
        input  ready
    );
    modport sink (
        input  valid, query_index, match_index, matched, best_distance_sq,
        output ready
    );
endinterface

// File: hdl/drtm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drtm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/drtm_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_dist
// Squared-distance unit: sums lane squares of one chunk pair, then
// accumulates chunks into one distance per reference descriptor.
// ----------------------------------------------------------------------------
module drtm_dist
    import drtm_pkg::*;
#(
    parameter int LANES  = 8,
    parameter int DIST_W = 23
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dist_tag               i_tag,
    input  logic [LANES*ELEM_W-1:0] i_ref_data,
    input  logic [LANES*ELEM_W-1:0] i_qry_data,
    output logic                    o_dist_valid,
    output logic [DIST_W-1:0]       o_dist
);

    localparam int PART_W = $clog2(LANES * 65025 + 1);

    logic [PART_W-1:0] w_part;
    t_dist_tag         r_tag;
    logic [PART_W-1:0] r_part;
    logic [DIST_W-1:0] r_acc;
    logic [DIST_W-1:0] w_sum;
    logic              r_dist_valid;
    logic [DIST_W-1:0] r_dist;

    // Sum of lane squares for one chunk
    always_comb begin
        logic signed [ELEM_W:0]     diff;
        logic        [2*ELEM_W-1:0] sq;
        w_part = '0;
        for (int i = 0; i < LANES; i++) begin
            diff   = $signed({1'b0, i_ref_data[i*ELEM_W +: ELEM_W]})
                   - $signed({1'b0, i_qry_data[i*ELEM_W +: ELEM_W]});
            sq     = (2*ELEM_W)'(diff * diff);
            w_part = w_part + PART_W'(sq);
        end
    end

    // Register the chunk sum with its tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
        r_part <= w_part;
    end

    assign w_sum = (r_tag.first ? '0 : r_acc) + DIST_W'(r_part);

    // Accumulate chunks, emit on the last chunk of a reference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_valid <= 1'b0;
        end else begin
            r_dist_valid <= r_tag.valid && r_tag.last;
        end
        if (r_tag.valid) begin
            r_acc <= w_sum;
        end
        if (r_tag.valid && r_tag.last) begin
            r_dist <= w_sum;
        end
    end

    assign o_dist_valid = r_dist_valid;
    assign o_dist       = r_dist;

endmodule

// File: hdl/descriptor_ratio_test_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_ratio_test_matcher
// Stores reference descriptors in RAM and answers each query descriptor with
// the nearest reference by squared distance and a ratio-test verdict.
// ----------------------------------------------------------------------------
//  Channel   Dir  Transaction
//  i_in      in   chunk of LANES elements, or clear command
//  o_out     out  one match result per completed query
//  i_cfg_*   in   ratio_squared write, no read-back
//
//  A chunk passes the idle and chunk states; the first chunk of a descriptor
//  that has a destination first has its whole RAM slot zeroed in ST_ZERO.
//  A completed query scans the reference RAM one chunk per cycle, over
//  every stored reference, then drains and runs the ratio test.
//  Clear and unused codes are taken in idle. Reset is synchronous, active low.
//  A result waiting in the output register stalls only the next query's
//  result step; input keeps flowing until then.
// ----------------------------------------------------------------------------
module descriptor_ratio_test_matcher
    import drtm_pkg::*;
#(
    parameter int DESCRIPTOR_LENGTH = 128,
    parameter int LANE_COUNT        = 8,
    parameter int MAX_REFERENCES    = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    drtm_in_if.sink           i_in,
    drtm_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [RATIO_W-1:0] i_cfg_wdata
);

    localparam int LANES   = (LANE_COUNT > INPUT_LANES) ? INPUT_LANES : LANE_COUNT;
    localparam int CHUNKS  = (DESCRIPTOR_LENGTH + LANES - 1) / LANES;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int REF_W   = $clog2(MAX_REFERENCES);
    localparam int RDEPTH  = MAX_REFERENCES * CHUNKS;
    localparam int RADDR_W = $clog2(RDEPTH);
    localparam int DIST_W  = $clog2(DESCRIPTOR_LENGTH * 65025 + 1);
    localparam int PROD_W  = RATIO_W + DIST_W;
    localparam int DATA_W  = LANES * ELEM_W;

    t_state r_state, n_state;

    logic [1:0]        r_func;
    logic              r_last;
    logic [ELEM_W-1:0] r_elem [INPUT_LANES];
    logic [CHUNK_W-1:0] r_pos;
    logic [CHUNK_W-1:0] r_zc;
    logic [REF_W:0]    r_count;
    logic [RADDR_W:0]  r_slot_base;
    logic [QIDX_W-1:0] r_qcnt;
    logic [RATIO_W-1:0] r_ratio;
    logic [RADDR_W:0]  r_iss;
    logic [CHUNK_W-1:0] r_qaddr;
    t_dist_tag         r_s1;
    logic [REF_W:0]    r_j;
    logic              r_have_best;
    logic              r_have_second;
    logic [DIST_W-1:0] r_best;
    logic [DIST_W-1:0] r_second;
    logic [REF_W-1:0]  r_best_idx;
    logic [PROD_W-1:0] r_prod;

    logic              r_out_valid;
    logic [QIDX_W-1:0] r_out_qidx;
    logic [MIDX_W-1:0] r_out_midx;
    logic              r_out_matched;
    logic [ODIST_W-1:0] r_out_dist;

    // Control strobes from the state machine
    logic s_accept, s_clear, s_latch, s_zero, s_write, s_step, s_done;
    logic s_ref_end, s_scan_init, s_issue, s_mult, s_load;

    logic              w_in_dest;
    logic              w_dest;
    logic              w_room;
    logic              w_chunk_done;
    logic [DATA_W-1:0] w_chunk;
    logic              w_ref_we, w_qry_we;
    logic [RADDR_W-1:0] w_ref_waddr;
    logic [CHUNK_W-1:0] w_qry_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [DATA_W-1:0] w_ref_rdata, w_qry_rdata;
    t_dist_tag         n_s1;
    logic              w_dist_valid;
    logic [DIST_W-1:0] w_dist;
    logic              w_matched;
    logic [31:0]       w_best32;
    logic [31:0]       w_idx32;
    logic [ODIST_W-1:0] w_out_dist;

    assign w_room    = r_count < (REF_W + 1)'(MAX_REFERENCES);
    assign w_in_dest = (i_in.func == FUNC_QRY) || ((i_in.func == FUNC_REF) && w_room);
    assign w_dest    = (r_func == FUNC_QRY) || ((r_func == FUNC_REF) && w_room);
    assign w_chunk_done = r_last || ((32'(r_pos) + 32'd1) >= 32'(CHUNKS));

    // Pack the latched chunk, zeroing lanes past the descriptor end
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if ((32'(r_pos) * LANES + i) < DESCRIPTOR_LENGTH) begin
                w_chunk[i*ELEM_W +: ELEM_W] = r_elem[i];
            end else begin
                w_chunk[i*ELEM_W +: ELEM_W] = '0;
            end
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state     = r_state;
        s_accept    = 1'b0;
        s_clear     = 1'b0;
        s_latch     = 1'b0;
        s_zero      = 1'b0;
        s_write     = 1'b0;
        s_step      = 1'b0;
        s_done      = 1'b0;
        s_ref_end   = 1'b0;
        s_scan_init = 1'b0;
        s_issue     = 1'b0;
        s_mult      = 1'b0;
        s_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_accept = 1'b1;
                if (i_in.valid) begin
                    if (i_in.func == FUNC_CLR) begin
                        s_clear = 1'b1;
                    end else if (i_in.func != FUNC_NOP) begin
                        s_latch = 1'b1;
                        if ((r_pos == '0) && w_in_dest) begin
                            n_state = ST_ZERO;
                        end else begin
                            n_state = ST_CHUNK;
                        end
                    end
                end
            end
            ST_ZERO: begin
                s_zero = 1'b1;
                if (32'(r_zc) == CHUNKS - 1) begin
                    n_state = ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                s_write = w_dest;
                if (!w_chunk_done) begin
                    s_step  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    s_done = 1'b1;
                    if (r_func == FUNC_REF) begin
                        s_ref_end = w_room;
                        n_state   = ST_IDLE;
                    end else begin
                        s_scan_init = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_iss < r_slot_base) begin
                    s_issue = 1'b1;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_j == r_count) begin
                    n_state = ST_RATIO;
                end
            end
            ST_RATIO: begin
                s_mult  = 1'b1;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    s_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = s_accept;

    // Control registers: position, count, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_zc        <= '0;
            r_count     <= '0;
            r_slot_base <= '0;
            r_qcnt      <= '0;
            r_ratio     <= RATIO_RESET;
            r_iss       <= '0;
            r_qaddr     <= '0;
            r_s1        <= '0;
            r_j         <= '0;
            r_have_best   <= 1'b0;
            r_have_second <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ratio <= i_cfg_wdata;
            end
            if (s_clear) begin
                r_pos       <= '0;
                r_count     <= '0;
                r_slot_base <= '0;
                r_qcnt      <= '0;
            end
            if (s_latch) begin
                r_zc <= '0;
            end else if (s_zero) begin
                r_zc <= r_zc + 1'b1;
            end
            if (s_step) begin
                r_pos <= r_pos + 1'b1;
            end else if (s_done) begin
                r_pos <= '0;
            end
            if (s_ref_end) begin
                r_count     <= r_count + 1'b1;
                r_slot_base <= r_slot_base + (RADDR_W + 1)'(CHUNKS);
            end
            // Scan address generation
            if (s_scan_init) begin
                r_iss   <= '0;
                r_qaddr <= '0;
            end else if (s_issue) begin
                r_iss <= r_iss + 1'b1;
                if (32'(r_qaddr) == CHUNKS - 1) begin
                    r_qaddr <= '0;
                end else begin
                    r_qaddr <= r_qaddr + 1'b1;
                end
            end
            r_s1 <= n_s1;
            // Nearest and second-nearest tracking
            if (s_scan_init) begin
                r_j           <= '0;
                r_have_best   <= 1'b0;
                r_have_second <= 1'b0;
            end else if (w_dist_valid) begin
                r_j <= r_j + 1'b1;
                if (!r_have_best || (w_dist < r_best)) begin
                    r_have_best <= 1'b1;
                    if (r_have_best) begin
                        r_have_second <= 1'b1;
                    end
                end else if (!r_have_second || (w_dist < r_second)) begin
                    r_have_second <= 1'b1;
                end
            end
            if (s_load) begin
                r_out_valid <= 1'b1;
                r_qcnt      <= r_qcnt + 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_latch) begin
            r_func    <= i_in.func;
            r_last    <= i_in.last_chunk;
            r_elem[0] <= i_in.elem_0;
            r_elem[1] <= i_in.elem_1;
            r_elem[2] <= i_in.elem_2;
            r_elem[3] <= i_in.elem_3;
            r_elem[4] <= i_in.elem_4;
            r_elem[5] <= i_in.elem_5;
            r_elem[6] <= i_in.elem_6;
            r_elem[7] <= i_in.elem_7;
        end
        if (s_scan_init) begin
            r_best_idx <= '0;
        end else if (w_dist_valid) begin
            if (!r_have_best || (w_dist < r_best)) begin
                if (r_have_best) begin
                    r_second <= r_best;
                end
                r_best     <= w_dist;
                r_best_idx <= r_j[REF_W-1:0];
            end else if (!r_have_second || (w_dist < r_second)) begin
                r_second <= w_dist;
            end
        end
        if (s_mult) begin
            r_prod <= PROD_W'(r_ratio) * PROD_W'(r_second);
        end
        if (s_load) begin
            r_out_qidx    <= r_qcnt;
            r_out_midx    <= w_idx32[MIDX_W-1:0];
            r_out_matched <= w_matched;
            r_out_dist    <= w_out_dist;
        end
    end

    // Ratio test and saturated distance
    assign w_best32 = 32'(r_best);
    assign w_idx32  = 32'(r_best_idx);
    always_comb begin
        if (!r_have_best) begin
            w_matched = 1'b0;
        end else if (!r_have_second) begin
            w_matched = (r_ratio != '0);
        end else begin
            w_matched = PROD_W'({r_best, {FRAC_W{1'b0}}}) < r_prod;
        end
        if (!r_have_best || (w_best32 > 32'(DIST_SAT))) begin
            w_out_dist = DIST_SAT;
        end else begin
            w_out_dist = w_best32[ODIST_W-1:0];
        end
    end

    // RAM write steering: zero sweep or chunk write
    always_comb begin
        w_ref_we    = 1'b0;
        w_qry_we    = 1'b0;
        w_ref_waddr = r_slot_base[RADDR_W-1:0] + RADDR_W'(r_pos);
        w_qry_waddr = r_pos;
        w_wdata     = w_chunk;
        if (s_zero) begin
            w_ref_waddr = r_slot_base[RADDR_W-1:0] + RADDR_W'(r_zc);
            w_qry_waddr = r_zc;
            w_wdata     = '0;
            w_ref_we    = (r_func == FUNC_REF);
            w_qry_we    = (r_func == FUNC_QRY);
        end else if (s_write) begin
            w_ref_we = (r_func == FUNC_REF);
            w_qry_we = (r_func == FUNC_QRY);
        end
    end

    // Tag for the chunk read issued this cycle
    always_comb begin
        n_s1.valid = s_issue;
        n_s1.first = (r_qaddr == '0);
        n_s1.last  = (32'(r_qaddr) == CHUNKS - 1);
    end

    drtm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RDEPTH)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (w_ref_we),
        .i_waddr (w_ref_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_iss[RADDR_W-1:0]),
        .o_rdata (w_ref_rdata)
    );

    drtm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CHUNKS)
    ) u_qry_ram (
        .i_clk   (i_clk),
        .i_we    (w_qry_we),
        .i_waddr (w_qry_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_qaddr),
        .o_rdata (w_qry_rdata)
    );

    drtm_dist #(
        .LANES  (LANES),
        .DIST_W (DIST_W)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (r_s1),
        .i_ref_data   (w_ref_rdata),
        .i_qry_data   (w_qry_rdata),
        .o_dist_valid (w_dist_valid),
        .o_dist       (w_dist)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.query_index      = r_out_qidx;
    assign o_out.match_index      = r_out_midx;
    assign o_out.matched          = r_out_matched;
    assign o_out.best_distance_sq = r_out_dist;

endmodule
